// ===== rtl/core/clc_pkg.sv =====
// Shared types and constants for the convex layer counter.
// Holds the point format, the cross-product unit interface and the state encodings.
// No dependencies.
package clc_pkg;

  localparam int MaxPoints = 1024;
  localparam int CoordBits = 31;
  localparam int IdxW      = $clog2(MaxPoints + 1);
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CountW    = 11;
  localparam int DiffW     = CoordBits + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int ResW      = ProdW + 1;

  typedef struct packed {
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] x;
  } pt_t;

  typedef enum logic {
    CU_CROSS,
    CU_DIST
  } cu_op_e;

  typedef struct packed {
    logic   start;
    cu_op_e op;
    pt_t    a;
    pt_t    b;
    pt_t    c;
  } cu_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [ResW-1:0] res;
  } cu_rsp_t;

  typedef enum logic [1:0] {
    CU_IDLE,
    CU_MUL1,
    CU_MUL2,
    CU_SUM
  } cu_state_e;

  typedef enum logic [5:0] {
    S_IDLE, S_RND, S_MIN0, S_MINRD, S_MINCMP, S_SWRD, S_SWW1, S_SWW2,
    S_ISTOP, S_IST, S_ISCHK, S_ISCMP, S_ISCR, S_ISDA, S_ISDB, S_ISSTEP, S_ISPUT,
    S_GSTOP, S_GSLOOP, S_GSFA, S_GSFB, S_GSFC, S_GSOR, S_GSCL, S_GSCLD, S_GSCLW,
    S_GSPK, S_GSSWAP, S_GSSWR, S_GSSWW,
    S_CLA, S_CLB, S_CLC, S_CLTOP, S_CLD, S_CLW,
    S_HA, S_HB, S_HC, S_HD, S_HW,
    S_CPRD, S_CPWR, S_EMIT
  } seq_state_e;

endpackage

// ===== rtl/core/clc_cross_unit.sv =====
// Shared arithmetic unit: one signed 32x32 multiplier used twice per request.
// Forms (b-a)x(c-a) or |b-a|^2. Depends on clc_pkg.
module clc_cross_unit import clc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cu_req_t req_i,
  output cu_rsp_t rsp_o
);

  cu_state_e state_q, state_d;

  logic signed [DiffW-1:0] d1_q, d2_q, d3_q, d4_q;
  logic signed [DiffW-1:0] d1_n, d2_n, d3_n, d4_n;
  logic signed [DiffW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] prod, p1_q, p2_q;
  logic signed [ResW-1:0]  res_q;
  cu_op_e                  op_q;
  logic                    done_q;

  assign d1_n = DiffW'(req_i.b.x) - DiffW'(req_i.a.x);
  assign d3_n = DiffW'(req_i.b.y) - DiffW'(req_i.a.y);
  assign d2_n = (req_i.op == CU_CROSS) ? DiffW'(req_i.c.y) - DiffW'(req_i.a.y) : d1_n;
  assign d4_n = (req_i.op == CU_CROSS) ? DiffW'(req_i.c.x) - DiffW'(req_i.a.x) : d3_n;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CU_IDLE: if (req_i.start) state_d = CU_MUL1;
      CU_MUL1: state_d = CU_MUL2;
      CU_MUL2: state_d = CU_SUM;
      CU_SUM:  state_d = CU_IDLE;
      default: state_d = CU_IDLE;
    endcase
  end

  always_comb begin
    mul_a = (state_q == CU_MUL1) ? d1_q : d3_q;
    mul_b = (state_q == CU_MUL1) ? d2_q : d4_q;
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CU_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == CU_SUM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CU_IDLE && req_i.start) begin
      d1_q <= d1_n;
      d2_q <= d2_n;
      d3_q <= d3_n;
      d4_q <= d4_n;
      op_q <= req_i.op;
    end
    if (state_q == CU_MUL1) p1_q <= prod;
    if (state_q == CU_MUL2) p2_q <= prod;
    if (state_q == CU_SUM) begin
      if (op_q == CU_CROSS) res_q <= ResW'(p1_q) - ResW'(p2_q);
      else                  res_q <= ResW'(p1_q) + ResW'(p2_q);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// ===== rtl/core/convex_layer_counter_top.sv =====
// Top level of the convex layer counter: point memories and the peeling sequencer.
// Depends on clc_pkg and clc_cross_unit.
//
// Points arrive one transaction per cycle while ready is high and are written straight
// into the point memory; a transaction with set_end high closes the set. The block
// then drops ready and peels convex layers: per round a linear pivot search, an
// insertion sort by angle around the pivot, a Graham scan and a copy of the inner
// points back into the point memory. Every angle, orientation and distance test runs
// on a single shared multiplier unit, and every point memory access goes through
// that memory's one registered read port. Each sorting step asks the unit for at most
// one cross product, and for two distances more when the two points share an angle.
// When peeling ends one result transaction carries the layer count and the overflow
// flag; points beyond 1024 are dropped and set the flag. The result waits in an
// output register, so loading of the next set may begin before it is taken. No
// clearing pass is needed after reset.
module convex_layer_counter_top import clc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [CoordBits-1:0] coord_x_i,
  input  logic signed [CoordBits-1:0] coord_y_i,
  input  logic                        set_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [CountW-1:0]           layer_count_o,
  output logic                        overflow_o
);

  seq_state_e state_q, state_d;

  // Control counters; sized to hold the full point count.
  logic [IdxW-1:0]   total_q, total_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IdxW-1:0]   best_q, best_d, ni_q, ni_d, nb_q, nb_d;
  logic [CountW-1:0] tally_q, tally_d, out_count_q, out_count_d;
  logic              ovf_q, ovf_d, out_valid_q, out_valid_d, out_ovf_q, out_ovf_d;
  logic              phase_q, phase_d, prec_q, prec_d;

  // Point registers: best, pivot, sort key, sort neighbour and scan operands.
  pt_t bp_q, bp_d, pv_q, pv_d, t_q, t_d, w_q, w_d;
  pt_t a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic signed [ResW-1:0] da_q, da_d;

  // Memories, each with one write and one registered read port.
  pt_t             ps_mem [MaxPoints];
  pt_t             in_mem [MaxPoints];
  pt_t             cs_mem [MaxPoints];
  pt_t             ps_rdata, in_rdata, cs_rdata, ps_wdata, in_wdata, cs_wdata;
  logic [AddrW-1:0] ps_raddr, in_raddr, cs_raddr, ps_waddr, in_waddr, cs_waddr;
  logic             ps_we, in_we, cs_we;

  cu_req_t cu_req;
  cu_rsp_t cu_rsp;
  logic    cu_neg, cu_zero;

  logic [IdxW-1:0] k_m1, k_p1, j_m1, nb_m1, ni_m1, m_last;
  logic            has_room, ni_room, nb_room, better, in_acc;

  clc_cross_unit u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cu_req),
    .rsp_o  (cu_rsp)
  );

  assign cu_neg  = cu_rsp.res[ResW-1];
  assign cu_zero = (cu_rsp.res == '0);

  assign k_m1   = k_q - 1'b1;
  assign k_p1   = k_q + 1'b1;
  assign j_m1   = j_q - 1'b1;
  assign nb_m1  = nb_q - 1'b1;
  assign ni_m1  = ni_q - 1'b1;
  // Last hull vertex index: min(k+1, n) - 1.
  assign m_last = (k_p1 < total_q) ? k_q : total_q - 1'b1;

  assign has_room = (total_q < IdxW'(MaxPoints));
  assign ni_room  = (ni_q < IdxW'(MaxPoints));
  assign nb_room  = (nb_q < IdxW'(MaxPoints));
  assign better   = (ps_rdata.y < bp_q.y) || ((ps_rdata.y == bp_q.y) && (ps_rdata.x > bp_q.x));
  assign in_acc   = in_valid_i && in_ready_o;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign layer_count_o = out_count_q;
  assign overflow_o    = out_ovf_q;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i && set_end_i) state_d = S_RND;
      S_RND:    state_d = (total_q >= IdxW'(3)) ? S_MIN0 : S_EMIT;
      S_MIN0:   state_d = S_MINRD;
      S_MINRD:  state_d = (i_q == total_q) ? S_SWRD : S_MINCMP;
      S_MINCMP: state_d = S_MINRD;
      S_SWRD:   state_d = S_SWW1;
      S_SWW1:   state_d = S_SWW2;
      S_SWW2:   state_d = S_ISTOP;
      S_ISTOP:  state_d = (i_q >= total_q) ? S_GSTOP : S_IST;
      S_IST:    state_d = S_ISCHK;
      S_ISCHK:  state_d = (j_q <= IdxW'(1)) ? S_ISPUT : S_ISCMP;
      S_ISCMP:  state_d = ((t_q == pv_q) || (ps_rdata == pv_q)) ? S_ISSTEP : S_ISCR;
      S_ISCR:   if (cu_rsp.done) state_d = cu_zero ? S_ISDA : S_ISSTEP;
      S_ISDA:   if (cu_rsp.done) state_d = S_ISDB;
      S_ISDB:   if (cu_rsp.done) state_d = S_ISSTEP;
      S_ISSTEP: state_d = prec_q ? S_ISCHK : S_ISPUT;
      S_ISPUT:  state_d = S_ISTOP;
      S_GSTOP:  state_d = (i_q >= total_q) ? S_CLA : S_GSLOOP;
      S_GSLOOP: state_d = (k_q == '0) ? S_GSSWAP : S_GSFA;
      S_GSFA:   state_d = S_GSFB;
      S_GSFB:   state_d = S_GSFC;
      S_GSFC:   state_d = S_GSOR;
      S_GSOR: begin
        if (cu_rsp.done) begin
          if (!phase_q && cu_neg) state_d = S_GSCL;
          else if (cu_zero)       state_d = S_GSLOOP;
          else                    state_d = S_GSSWAP;
        end
      end
      S_GSCL:   state_d = (nb_q == '0) ? S_GSPK : S_GSCLD;
      S_GSCLD:  state_d = S_GSCLW;
      S_GSCLW:  if (cu_rsp.done) state_d = cu_zero ? S_GSCL : S_GSPK;
      S_GSPK:   state_d = S_GSLOOP;
      S_GSSWAP: state_d = S_GSSWR;
      S_GSSWR:  state_d = S_GSSWW;
      S_GSSWW:  state_d = S_GSTOP;
      S_CLA:    state_d = S_CLB;
      S_CLB:    state_d = S_CLC;
      S_CLC:    state_d = S_CLTOP;
      S_CLTOP:  state_d = (ni_q == '0) ? S_HA : S_CLD;
      S_CLD:    state_d = S_CLW;
      S_CLW:    if (cu_rsp.done) state_d = cu_zero ? S_CLTOP : S_HA;
      S_HA:     state_d = S_HB;
      S_HB:     state_d = S_HC;
      S_HC:     state_d = S_HD;
      S_HD:     state_d = S_HW;
      S_HW:     if (cu_rsp.done) state_d = S_CPRD;
      S_CPRD:   state_d = (i_q == ni_q) ? S_RND : S_CPWR;
      S_CPWR:   state_d = S_CPRD;
      S_EMIT:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath controls, memory strobes and register updates.
  always_comb begin
    total_d = total_q;  i_d = i_q;  j_d = j_q;  k_d = k_q;
    best_d = best_q;  ni_d = ni_q;  nb_d = nb_q;
    tally_d = tally_q;  ovf_d = ovf_q;  phase_d = phase_q;  prec_d = prec_q;
    bp_d = bp_q;  pv_d = pv_q;  t_d = t_q;  w_d = w_q;
    a_d = a_q;  b_d = b_q;  c_d = c_q;  d_d = d_q;  da_d = da_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_count_d = out_count_q;
    out_ovf_d   = out_ovf_q;
    ps_raddr = '0;  in_raddr = '0;  cs_raddr = '0;
    ps_we = 1'b0;  in_we = 1'b0;  cs_we = 1'b0;
    ps_waddr = '0;  in_waddr = '0;  cs_waddr = '0;
    ps_wdata = '0;  in_wdata = '0;  cs_wdata = '0;
    cu_req = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (has_room) begin
            ps_we    = 1'b1;
            ps_waddr = total_q[AddrW-1:0];
            ps_wdata = '{y: coord_y_i, x: coord_x_i};
            total_d  = total_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (set_end_i) tally_d = '0;
        end
      end
      S_RND: ps_raddr = '0;
      S_MIN0: begin
        bp_d   = ps_rdata;
        best_d = '0;
        i_d    = IdxW'(1);
      end
      S_MINRD: ps_raddr = i_q[AddrW-1:0];
      S_MINCMP: begin
        if (better) begin
          bp_d   = ps_rdata;
          best_d = i_q;
        end
        i_d = i_q + 1'b1;
      end
      S_SWRD: ps_raddr = '0;
      S_SWW1: begin
        ps_we    = 1'b1;
        ps_waddr = best_q[AddrW-1:0];
        ps_wdata = ps_rdata;
      end
      S_SWW2: begin
        ps_we    = 1'b1;
        ps_waddr = '0;
        ps_wdata = bp_q;
        pv_d     = bp_q;
        i_d      = IdxW'(2);
      end
      S_ISTOP: begin
        if (i_q >= total_q) begin
          k_d  = IdxW'(1);
          i_d  = IdxW'(2);
          nb_d = '0;
          ni_d = '0;
        end else begin
          ps_raddr = i_q[AddrW-1:0];
        end
      end
      S_IST: begin
        t_d = ps_rdata;
        j_d = i_q;
      end
      S_ISCHK: ps_raddr = j_m1[AddrW-1:0];
      S_ISCMP: begin
        w_d = ps_rdata;
        // A vector equal to the pivot sorts before every other one.
        if (t_q == pv_q) begin
          prec_d = (ps_rdata != pv_q);
        end else if (ps_rdata == pv_q) begin
          prec_d = 1'b0;
        end else begin
          cu_req.start = 1'b1;
          cu_req.op    = CU_CROSS;
          cu_req.a     = pv_q;
          cu_req.b     = t_q;
          cu_req.c     = ps_rdata;
        end
      end
      S_ISCR: begin
        if (cu_rsp.done) begin
          if (cu_zero) begin
            cu_req.start = 1'b1;
            cu_req.op    = CU_DIST;
            cu_req.a     = pv_q;
            cu_req.b     = t_q;
          end else begin
            prec_d = !cu_neg;
          end
        end
      end
      S_ISDA: begin
        if (cu_rsp.done) begin
          da_d         = cu_rsp.res;
          cu_req.start = 1'b1;
          cu_req.op    = CU_DIST;
          cu_req.a     = pv_q;
          cu_req.b     = w_q;
        end
      end
      S_ISDB: if (cu_rsp.done) prec_d = (da_q < cu_rsp.res);
      S_ISSTEP: begin
        if (prec_q) begin
          ps_we    = 1'b1;
          ps_waddr = j_q[AddrW-1:0];
          ps_wdata = w_q;
          j_d      = j_m1;
        end
      end
      S_ISPUT: begin
        ps_we    = 1'b1;
        ps_waddr = j_q[AddrW-1:0];
        ps_wdata = t_q;
        i_d      = i_q + 1'b1;
      end
      S_GSTOP:  phase_d = 1'b0;
      S_GSLOOP: ps_raddr = k_m1[AddrW-1:0];
      S_GSFA: begin
        a_d      = ps_rdata;
        ps_raddr = k_q[AddrW-1:0];
      end
      S_GSFB: begin
        b_d      = ps_rdata;
        ps_raddr = i_q[AddrW-1:0];
      end
      S_GSFC: begin
        c_d          = ps_rdata;
        cu_req.start = 1'b1;
        cu_req.op    = CU_CROSS;
        cu_req.a     = a_q;
        cu_req.b     = b_q;
        cu_req.c     = ps_rdata;
      end
      S_GSOR: begin
        // A collinear top point waits on the collinear stack.
        if (cu_rsp.done && !(!phase_q && cu_neg) && cu_zero) begin
          if (nb_room) begin
            cs_we    = 1'b1;
            cs_waddr = nb_q[AddrW-1:0];
            cs_wdata = b_q;
            nb_d     = nb_q + 1'b1;
          end
          k_d     = k_m1;
          phase_d = 1'b1;
        end
      end
      S_GSCL: cs_raddr = nb_m1[AddrW-1:0];
      S_GSCLD: begin
        d_d          = cs_rdata;
        cu_req.start = 1'b1;
        cu_req.op    = CU_CROSS;
        cu_req.a     = a_q;
        cu_req.b     = b_q;
        cu_req.c     = cs_rdata;
      end
      S_GSCLW: begin
        if (cu_rsp.done && cu_zero) begin
          nb_d = nb_m1;
          if (ni_room) begin
            in_we    = 1'b1;
            in_waddr = ni_q[AddrW-1:0];
            in_wdata = d_q;
            ni_d     = ni_q + 1'b1;
          end
        end
      end
      S_GSPK: begin
        if (ni_room) begin
          in_we    = 1'b1;
          in_waddr = ni_q[AddrW-1:0];
          in_wdata = b_q;
          ni_d     = ni_q + 1'b1;
        end
        k_d = k_m1;
      end
      S_GSSWAP: ps_raddr = k_p1[AddrW-1:0];
      S_GSSWR: begin
        ps_we    = 1'b1;
        ps_waddr = i_q[AddrW-1:0];
        ps_wdata = ps_rdata;
      end
      S_GSSWW: begin
        ps_we    = 1'b1;
        ps_waddr = k_p1[AddrW-1:0];
        ps_wdata = c_q;
        k_d      = k_p1;
        i_d      = i_q + 1'b1;
      end
      S_CLA: ps_raddr = '0;
      S_CLB: begin
        a_d      = ps_rdata;
        ps_raddr = k_q[AddrW-1:0];
      end
      S_CLC:   b_d = ps_rdata;
      S_CLTOP: in_raddr = ni_m1[AddrW-1:0];
      S_CLD: begin
        cu_req.start = 1'b1;
        cu_req.op    = CU_CROSS;
        cu_req.a     = a_q;
        cu_req.b     = b_q;
        cu_req.c     = in_rdata;
      end
      S_CLW: if (cu_rsp.done && cu_zero) ni_d = ni_m1;
      S_HA:  ps_raddr = '0;
      S_HB: begin
        a_d      = ps_rdata;
        ps_raddr = AddrW'(1);
      end
      S_HC: begin
        b_d      = ps_rdata;
        ps_raddr = m_last[AddrW-1:0];
      end
      S_HD: begin
        cu_req.start = 1'b1;
        cu_req.op    = CU_CROSS;
        cu_req.a     = a_q;
        cu_req.b     = b_q;
        cu_req.c     = ps_rdata;
      end
      S_HW: begin
        if (cu_rsp.done) begin
          if (!cu_zero) tally_d = tally_q + 1'b1;
          i_d = '0;
        end
      end
      S_CPRD: begin
        if (i_q == ni_q) total_d = ni_q;
        else             in_raddr = i_q[AddrW-1:0];
      end
      S_CPWR: begin
        ps_we    = 1'b1;
        ps_waddr = i_q[AddrW-1:0];
        ps_wdata = in_rdata;
        i_d      = i_q + 1'b1;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_count_d = tally_q;
          out_ovf_d   = ovf_q;
          total_d     = '0;
          ovf_d       = 1'b0;
          tally_d     = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      tally_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      best_q      <= '0;
      ni_q        <= '0;
      nb_q        <= '0;
      phase_q     <= 1'b0;
      prec_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      tally_q     <= tally_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      best_q      <= best_d;
      ni_q        <= ni_d;
      nb_q        <= nb_d;
      phase_q     <= phase_d;
      prec_q      <= prec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q        <= bp_d;
    pv_q        <= pv_d;
    t_q         <= t_d;
    w_q         <= w_d;
    a_q         <= a_d;
    b_q         <= b_d;
    c_q         <= c_d;
    d_q         <= d_d;
    da_q        <= da_d;
    out_count_q <= out_count_d;
    out_ovf_q   <= out_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (ps_we) ps_mem[ps_waddr] <= ps_wdata;
    ps_rdata <= ps_mem[ps_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_we) in_mem[in_waddr] <= in_wdata;
    in_rdata <= in_mem[in_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) cs_mem[cs_waddr] <= cs_wdata;
    cs_rdata <= cs_mem[cs_raddr];
  end

  // The shared unit only answers while the sequencer waits for it.
  a_cu_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cu_rsp.done |-> (state_q == S_ISCR || state_q == S_ISDA || state_q == S_ISDB ||
                     state_q == S_GSOR || state_q == S_GSCLW || state_q == S_CLW ||
                     state_q == S_HW))
    else $error("cross unit answered outside a wait state");

  // The scan top always lies below the point being considered.
  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GSTOP && i_q < total_q) |-> (k_q < i_q))
    else $error("scan index ordering broken");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q <= IdxW'(MaxPoints)) && (ni_q <= IdxW'(MaxPoints)) &&
    (nb_q <= IdxW'(MaxPoints)))
    else $error("point count beyond capacity");

  // Emitting a result leaves the block empty for the next set.
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && state_d == S_IDLE) |=> (total_q == '0 && !ovf_q && out_valid_q))
    else $error("result emission did not clear the set");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for convex_layer_counter_top: point sets are streamed in,
// and each layer count is compared with a local model of the onion-peeling scheme.
// Depends on clc_pkg and the convex_layer_counter_top RTL.
`timescale 1ns / 100ps

module testbench import clc_pkg::*; ();

  // Far above the slowest correct run: small sets, one long overflow set of
  // repeated points, and both sides stalling about a quarter of the time.
  localparam int unsigned CycleLimit = 6000000;
  localparam int          PtDepth    = 1024;

  typedef struct packed {
    logic [CountW-1:0] layers;
    logic              ovf;
  } layer_result_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic signed [CoordBits-1:0] coord_x_i = '0;
  logic signed [CoordBits-1:0] coord_y_i = '0;
  logic                        set_end_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [CountW-1:0]           layer_count_o;
  logic                        overflow_o;

  // Peeling model state: the current point set and the scratch stores of the scan.
  longint set_x [PtDepth];
  longint set_y [PtDepth];
  longint inner_x [PtDepth];
  longint inner_y [PtDepth];
  longint coll_x [PtDepth];
  longint coll_y [PtDepth];
  int     held_points;
  bit     points_dropped;

  layer_result_t pending_counts[$];
  int            fail_count;
  int            points_sent;
  int unsigned   cycle_count;
  // While set, neither side idles.
  bit            no_stall;

  convex_layer_counter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .set_end_i     (set_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .layer_count_o (layer_count_o),
    .overflow_o    (overflow_o)
  );

  always #6 clk_i = ~clk_i;

  // Turn direction of a->b->c: 1 for a right turn, -1 for a left turn, 0 if collinear.
  // Coordinate differences stay within 32 bits, so the products fit in 64 bits.
  function automatic int turn_of(longint ax, longint ay, longint bx, longint by,
                                 longint cx, longint cy);
    longint v;
    v = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    return (v < 0) ? 1 : ((v > 0) ? -1 : 0);
  endfunction

  // True if vector a comes before vector b in angle about the pivot. The zero
  // vector (a duplicate of the pivot) comes first; equal angles go nearest first.
  function automatic bit angle_first(longint ax, longint ay, longint bx, longint by);
    longint          c;
    longint unsigned da, db;
    if (ax == 0 && ay == 0) return !(bx == 0 && by == 0);
    if (bx == 0 && by == 0) return 1'b0;
    c = ax * by - ay * bx;
    if (c != 0) return c > 0;
    da = longint'(ax * ax) + longint'(ay * ay);
    db = longint'(bx * bx) + longint'(by * by);
    return da < db;
  endfunction

  function automatic void swap_points(int a, int b);
    longint t;
    t = set_x[a]; set_x[a] = set_x[b]; set_x[b] = t;
    t = set_y[a]; set_y[a] = set_y[b]; set_y[b] = t;
  endfunction

  // One round of peeling: hull by Graham scan, inner points become the new set.
  // Returns whether the hull found is non-degenerate.
  function automatic bit peel_layer();
    int     n, i, j, pivot, k, n_in, n_coll, m;
    longint pvx, pvy, tx, ty;
    bit     solid;
    n = held_points;
    n_in = 0;
    n_coll = 0;
    pivot = 0;
    for (i = 1; i < n; i++)
      if (set_y[i] < set_y[pivot] || (set_y[i] == set_y[pivot] && set_x[i] > set_x[pivot]))
        pivot = i;
    swap_points(0, pivot);
    pvx = set_x[0];
    pvy = set_y[0];
    for (i = 2; i < n; i++) begin
      tx = set_x[i];
      ty = set_y[i];
      j = i;
      while (j > 1 && angle_first(tx - pvx, ty - pvy, set_x[j-1] - pvx, set_y[j-1] - pvy)) begin
        set_x[j] = set_x[j-1];
        set_y[j] = set_y[j-1];
        j--;
      end
      set_x[j] = tx;
      set_y[j] = ty;
    end
    k = 1;
    for (i = 2; i < n; i++) begin
      while (k > 0 && turn_of(set_x[k-1], set_y[k-1], set_x[k], set_y[k],
                              set_x[i], set_y[i]) > 0) begin
        // Collinear points parked on this edge turn out to be inside as well.
        while (n_coll > 0 && turn_of(set_x[k-1], set_y[k-1], set_x[k], set_y[k],
                                     coll_x[n_coll-1], coll_y[n_coll-1]) == 0) begin
          n_coll--;
          if (n_in < PtDepth) begin
            inner_x[n_in] = coll_x[n_coll];
            inner_y[n_in] = coll_y[n_coll];
            n_in++;
          end
        end
        if (n_in < PtDepth) begin
          inner_x[n_in] = set_x[k];
          inner_y[n_in] = set_y[k];
          n_in++;
        end
        k--;
      end
      while (k > 0 && turn_of(set_x[k-1], set_y[k-1], set_x[k], set_y[k],
                              set_x[i], set_y[i]) == 0) begin
        if (n_coll < PtDepth) begin
          coll_x[n_coll] = set_x[k];
          coll_y[n_coll] = set_y[k];
          n_coll++;
        end
        k--;
      end
      swap_points(i, k + 1);
      k++;
    end
    // Inner points lying on the closing edge belong to this layer.
    while (n_in > 0 && turn_of(set_x[0], set_y[0], set_x[k], set_y[k],
                               inner_x[n_in-1], inner_y[n_in-1]) == 0)
      n_in--;
    m = (k + 1 < n) ? k + 1 : n;
    solid = turn_of(set_x[0], set_y[0], set_x[1], set_y[1], set_x[m-1], set_y[m-1]) != 0;
    for (i = 0; i < n_in; i++) begin
      set_x[i] = inner_x[i];
      set_y[i] = inner_y[i];
    end
    held_points = n_in;
    return solid;
  endfunction

  // Applies one accepted point to the model; a closing point queues the count.
  function automatic void absorb_point(logic signed [CoordBits-1:0] x,
                                       logic signed [CoordBits-1:0] y, logic last);
    layer_result_t r;
    int            layers;
    if (held_points < PtDepth) begin
      set_x[held_points] = longint'(x);
      set_y[held_points] = longint'(y);
      held_points++;
    end else begin
      points_dropped = 1'b1;
    end
    if (last) begin
      layers = 0;
      while (held_points >= 3)
        if (peel_layer()) layers++;
      r.layers = CountW'(layers);
      r.ovf = points_dropped;
      pending_counts.insert(pending_counts.size(), r);
      held_points = 0;
      points_dropped = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s is %0d, expected %0d", cycle_count, what, got, want);
    fail_count++;
  endtask

  // Sends one point and waits for its transaction; valid stays high between
  // back-to-back points and only drops for an idle gap.
  task automatic send_point(input logic signed [CoordBits-1:0] x,
                            input logic signed [CoordBits-1:0] y, input logic last);
    while (!no_stall && $urandom_range(99) < 24) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    coord_x_i = x;
    coord_y_i = y;
    set_end_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_point(x, y, last);
    points_sent++;
  endtask

  task automatic finish_sending();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Receiver stalls at random, updated on the falling edge.
  always @(negedge clk_i)
    out_ready_i <= no_stall || ($urandom_range(99) >= 24);

  // Each result transaction is checked against the oldest expected count.
  always @(posedge clk_i) begin
    layer_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_counts.size() == 0) begin
        report_mismatch("unexpected result, layer_count", layer_count_o, -1);
      end else begin
        want = pending_counts.pop_front();
        if (layer_count_o !== want.layers)
          report_mismatch("layer_count", layer_count_o, want.layers);
        if (overflow_o !== want.ovf)
          report_mismatch("overflow", overflow_o, want.ovf);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** convex_layer_counter_top: FAILED **");
      $finish;
    end
  end

  localparam logic signed [CoordBits-1:0] CMin = {1'b1, {(CoordBits-1){1'b0}}};
  localparam logic signed [CoordBits-1:0] CMax = {1'b0, {(CoordBits-1){1'b1}}};

  // Small sets, degenerate hulls, pivot duplicates and the coordinate extremes.
  task automatic test_corner_sets();
    send_point(5, 5, 1'b1);                 // single point: no round
    send_point(1, 2, 1'b0);
    send_point(3, 4, 1'b1);                 // two points: no round
    send_point(0, 0, 1'b0);
    send_point(1, 1, 1'b0);
    send_point(2, 2, 1'b1);                 // collinear triple: degenerate hull
    send_point(CMin, CMin, 1'b0);           // extreme corners with a centre point
    send_point(CMax, CMin, 1'b0);
    send_point(CMax, CMax, 1'b0);
    send_point(CMin, CMax, 1'b0);
    send_point(0, 0, 1'b1);
    send_point(7, -3, 1'b0);                // repeats of the pivot
    send_point(7, -3, 1'b0);
    send_point(7, -3, 1'b0);
    send_point(9, 4, 1'b0);
    send_point(2, 6, 1'b1);
    send_point(0, 0, 1'b0);                 // square, an edge midpoint, two nested layers
    send_point(4, 0, 1'b0);
    send_point(4, 4, 1'b0);
    send_point(0, 4, 1'b0);
    send_point(2, 0, 1'b0);
    send_point(2, 1, 1'b0);
    send_point(1, 2, 1'b0);
    send_point(3, 2, 1'b1);
  endtask

  // More points than the store holds; the closing point itself is dropped too.
  // Identical points keep the peeling time linear in the set size.
  task automatic test_store_overflow();
    for (int i = 0; i < PtDepth + 6; i++)
      send_point(-11, 13, i == PtDepth + 5);
    send_point(1, 1, 1'b0);                 // flag must have cleared for this set
    send_point(2, 0, 1'b0);
    send_point(0, 3, 1'b1);
  endtask

  function automatic logic signed [CoordBits-1:0] pick_coord(int style);
    case (style)
      0: return CoordBits'($signed($urandom_range(8)) - 4);
      1: return CoordBits'($signed($urandom_range(2000)) - 1000);
      default: return CoordBits'($urandom);
    endcase
  endfunction

  // Random sets: mostly small, dense grids for collinear and repeated points,
  // plus wide and full-range sets.
  task automatic test_random_sets(input int target);
    int size, style;
    logic signed [CoordBits-1:0] x, y;
    while (points_sent < target) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(13, 22) : $urandom_range(1, 12);
      style = $urandom_range(3);
      for (int i = 0; i < size; i++) begin
        if (style == 3) begin
          // points on the lines x = k*y and x = k*y + 1
          y = CoordBits'($signed($urandom_range(20)) - 10);
          x = y * CoordBits'($urandom_range(2)) + CoordBits'($urandom_range(1));
        end else begin
          x = pick_coord(style);
          y = pick_coord(style);
        end
        send_point(x, y, i == size - 1);
      end
    end
  endtask

  // Back-to-back transactions on both sides.
  task automatic test_full_rate(input int target);
    no_stall = 1'b1;
    test_random_sets(target);
    no_stall = 1'b0;
  endtask

  initial begin
    fail_count = 0;
    points_sent = 0;
    cycle_count = 0;
    held_points = 0;
    points_dropped = 1'b0;
    no_stall = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_corner_sets();
    test_store_overflow();
    test_random_sets(points_sent + 120);
    test_full_rate(points_sent + 60);
    test_random_sets(points_sent + 30);
    finish_sending();

    wait (pending_counts.size() == 0);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** convex_layer_counter_top: PASSED **");
    end else begin
      $display("** convex_layer_counter_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/clc_pkg.sv
rtl/core/clc_cross_unit.sv
rtl/core/convex_layer_counter_top.sv
test/testbench.sv
